FILE: rtl/cba_pkg.sv
// Package for the centered boxcar average block.
// Holds the fixed field widths and register reset value; no dependencies.
`default_nettype none

package cba_pkg;

  localparam int unsigned KW = 4;
  localparam int unsigned MW = 5;

  localparam logic [KW-1:0] HALF_WIDTH_RESET = 4'd2;

endpackage

`default_nettype wire

FILE: rtl/centered_boxcar_average.sv
// Centered boxcar (moving average) filter over records of signed samples.
// Uses cba_pkg; the sample ring is a one-port-write, one-port-read synchronous memory.
//
// Usage:
//   in_*  : one sample per beat, tdata = sample (low SAMPLE_BITS), tlast = last of record.
//   out_* : one result per beat, tdata = value (low SAMPLE_BITS), tuser = averaged,
//           tlast = last result of the record.
//   cfg_* : writes half_width K (clamped to MAX_HALF_WIDTH); the window is 2K+1.
//           A write abandons any record in progress. Write only while idle.
// Output j appears while sample j+K is processed; the final sample of a record
// also flushes the last min(count, K) raw samples, oldest first.
// Timing: one sample at a time. A sample that yields a window mean passes through
// the restoring divider that retires one quotient bit per cycle; a raw sample and a
// silent one skip the divider, and the final sample of a record goes on to emit
// each flushed result in turn.
// Reset clears K to 2 and empties the record state; the ring needs no clearing.
// A stalled receiver holds the result in the output register; the next sample is
// still taken, and processing waits only when a new result finds that register full.
`default_nettype none

module centered_boxcar_average
  import cba_pkg::*;
#(
  parameter int MAX_HALF_WIDTH = 15,
  parameter int SAMPLE_BITS    = 24
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,   // sample
  input  wire logic                                 in_tlast,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic      [((SAMPLE_BITS+7)/8)*8-1:0]     out_tdata,  // value
  output logic                                      out_tuser,  // averaged
  output logic                                      out_tlast,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [KW-1:0]                        cfg_data    // half_width
);

  localparam int S          = SAMPLE_BITS;
  localparam int TW         = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int RING_DEPTH = 2 * MAX_HALF_WIDTH + 1;
  localparam int AW         = $clog2(RING_DEPTH);
  localparam int SW         = SAMPLE_BITS + MW;
  localparam int CW         = $clog2(SW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_DAT, S_PREP, S_DIV, S_EMM, S_EMR, S_FCHK, S_FRD, S_FEM
  } state_t;

  state_t                 state_r;
  logic [KW-1:0]          hw_r;
  logic [MW-1:0]          ptr_r;
  logic [MW-1:0]          seen_r;
  logic signed [SW-1:0]   sum_r;
  logic [S-1:0]           x_r;
  logic                   last_r;
  logic                   sat_r;
  logic                   emit_r;
  logic [KW-1:0]          fcnt_r;
  logic [SW-1:0]          num_r;
  logic [MW:0]            rem_r;
  logic                   neg_r;
  logic [CW-1:0]          cnt_r;
  logic                   out_tvalid_r;
  logic [S-1:0]           out_val_r;
  logic                   out_avg_r;
  logic                   out_last_r;

  logic [S-1:0]           ring_mem [RING_DEPTH];
  logic [S-1:0]           ring_q;
  logic                   ring_ren;
  logic [MW-1:0]          ring_raddr;
  logic [MW-1:0]          ptr_inc;

  logic [KW-1:0]          k;
  logic [MW-1:0]          m;
  logic [MW-1:0]          k2;
  logic                   in_acc;
  logic                   out_free;
  logic                   out_load;
  logic                   acc_sat;
  logic [MW-1:0]          acc_seen;
  logic [KW-1:0]          acc_fcnt;
  logic signed [SW-1:0]   x_ext;
  logic signed [SW-1:0]   ring_ext;
  logic signed [SW-1:0]   win_sum;
  logic [SW-1:0]          num_abs;
  logic [MW+1:0]          rem_sh;
  logic [MW+1:0]          div_d;
  logic                   div_ge;
  logic [S-1:0]           mean_mag;

  function automatic logic [MW-1:0] ring_sub(input logic [MW-1:0] a, input logic [MW-1:0] b,
                                             input logic [MW-1:0] mod);
    logic [MW:0] t;
    t = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      t = t + {1'b0, mod};
    end
    return t[MW-1:0];
  endfunction

  assign k        = (32'(hw_r) > MAX_HALF_WIDTH) ? KW'(MAX_HALF_WIDTH) : hw_r;
  assign m        = {k, 1'b1};
  assign k2       = {k, 1'b0};
  assign in_tready = (state_r == S_IDLE) && !cfg_valid;
  assign in_acc   = in_tvalid && in_tready;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_free = !out_tvalid_r || out_tready;
  assign out_load = out_free &&
                    ((state_r == S_EMM) || (state_r == S_EMR) || (state_r == S_FEM));
  assign ptr_inc  = (ptr_r + 1'b1 == m) ? '0 : ptr_r + 1'b1;

  assign acc_sat  = (seen_r >= k2);
  assign acc_seen = acc_sat ? seen_r : seen_r + 1'b1;
  assign acc_fcnt = !in_tlast ? '0 : ((acc_seen > {1'b0, k}) ? k : acc_seen[KW-1:0]);

  assign x_ext    = {{MW{x_r[S-1]}}, x_r};
  assign ring_ext = (k == '0) ? x_ext : {{MW{ring_q[S-1]}}, ring_q};
  assign win_sum  = sum_r + x_ext;
  assign num_abs  = num_r[SW-1] ? (~num_r + 1'b1) : num_r;
  assign div_d    = {1'b0, m, 1'b0};
  assign rem_sh   = {rem_r, num_r[SW-1]};
  assign div_ge   = (rem_sh >= div_d);
  assign mean_mag = neg_r ? (~num_r[S-1:0] + 1'b1) : num_r[S-1:0];

  always_comb begin
    ring_ren   = 1'b0;
    ring_raddr = ptr_r;
    case (state_r)
      S_RD: begin
        ring_ren   = 1'b1;
        ring_raddr = sat_r ? ptr_inc : ring_sub(ptr_r, {1'b0, k}, m);
      end
      S_FRD: begin
        ring_ren   = 1'b1;
        ring_raddr = ring_sub(ptr_r, {1'b0, fcnt_r - 1'b1}, m);
      end
      default: begin
        ring_ren   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring_mem[AW'(ptr_r)] <= in_tdata[S-1:0];
    end
    if (ring_ren) begin
      ring_q <= ring_mem[AW'(ring_raddr)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      hw_r         <= HALF_WIDTH_RESET;
      ptr_r        <= '0;
      seen_r       <= '0;
      sum_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            hw_r   <= cfg_data;
            ptr_r  <= '0;
            seen_r <= '0;
            sum_r  <= '0;
          end else if (in_acc) begin
            x_r     <= in_tdata[S-1:0];
            last_r  <= in_tlast;
            sat_r   <= acc_sat;
            emit_r  <= (seen_r >= {1'b0, k});
            fcnt_r  <= acc_fcnt;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_DAT;
        end
        S_DAT: begin
          if (sat_r) begin
            sum_r   <= win_sum - ring_ext;
            num_r   <= win_sum;
            neg_r   <= win_sum[SW-1];
            state_r <= S_PREP;
          end else begin
            sum_r   <= win_sum;
            seen_r  <= seen_r + 1'b1;
            state_r <= emit_r ? S_EMR : S_FCHK;
          end
        end
        S_PREP: begin
          num_r   <= {num_abs[SW-2:0], 1'b0} + SW'(m);
          rem_r   <= '0;
          cnt_r   <= CW'(SW);
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= div_ge ? (MW+1)'(rem_sh - div_d) : rem_sh[MW:0];
          num_r <= {num_r[SW-2:0], div_ge};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            state_r <= S_EMM;
          end
        end
        S_EMM: begin
          if (out_free) begin
            out_val_r    <= mean_mag;
            out_avg_r    <= 1'b1;
            out_last_r   <= last_r && (fcnt_r == '0);
            state_r      <= S_FCHK;
          end
        end
        S_EMR: begin
          if (out_free) begin
            out_val_r    <= ring_q;
            out_avg_r    <= 1'b0;
            out_last_r   <= last_r && (fcnt_r == '0);
            state_r      <= S_FCHK;
          end
        end
        S_FCHK: begin
          if (last_r && (fcnt_r != '0)) begin
            state_r <= S_FRD;
          end else begin
            if (last_r) begin
              ptr_r  <= '0;
              seen_r <= '0;
              sum_r  <= '0;
            end else begin
              ptr_r <= ptr_inc;
            end
            state_r <= S_IDLE;
          end
        end
        S_FRD: begin
          state_r <= S_FEM;
        end
        S_FEM: begin
          if (out_free) begin
            out_val_r    <= ring_q;
            out_avg_r    <= 1'b0;
            out_last_r   <= (fcnt_r == KW'(1));
            fcnt_r       <= fcnt_r - 1'b1;
            state_r      <= S_FCHK;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = TW'(out_val_r);
  assign out_tuser  = out_avg_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
